### rtl/pisc_pkg.sv
// Package for the PI speed controller with deadband.
// Holds widths, register codes, reset values, the configuration type and the inter-stage type.
// No dependencies.
package pisc_pkg;

  localparam int DataW    = 16;
  localparam int DbW      = 15;
  localparam int ErrW     = DataW + 1;
  localparam int IntW     = 18;
  localparam int GainW    = 16;
  localparam int CfgIdxW  = 3;
  localparam int ProdPW   = ErrW + GainW + 1;
  localparam int ProdIW   = IntW + GainW + 1;
  localparam int SumW     = ProdIW + 1;
  localparam int FracSh   = 16;
  localparam int QW       = SumW - FracSh;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEADBAND  = 3'd0,
    CFG_DRIVE_MIN = 3'd1,
    CFG_DRIVE_MAX = 3'd2,
    CFG_KP        = 3'd3,
    CFG_KI        = 3'd4,
    CFG_INT_LIMIT = 3'd5
  } cfg_idx_e;

  localparam logic [DbW-1:0]          DeadbandRst  = 15'd0;
  localparam logic signed [DataW-1:0] DriveMinRst  = -16'sd4096;
  localparam logic signed [DataW-1:0] DriveMaxRst  = 16'sd4096;
  localparam logic [GainW-1:0]        KpRst        = 16'd52429;
  localparam logic [GainW-1:0]        KiRst        = 16'd2621;
  localparam logic [DataW-1:0]        IntLimitRst  = 16'd8192;

  typedef struct packed {
    logic [DbW-1:0]          deadband;
    logic signed [DataW-1:0] drive_min;
    logic signed [DataW-1:0] drive_max;
    logic [GainW-1:0]        kp;
    logic [GainW-1:0]        ki;
    logic [DataW-1:0]        integral_limit;
  } cfg_t;

  // Output of the integrator stage
  typedef struct packed {
    logic                   valid;
    logic                   in_db;
    logic signed [ErrW-1:0] err;
    logic signed [IntW-1:0] acc;
  } integ_t;

endpackage

### rtl/pisc_if.sv
// Handshake channel interfaces for the PI speed controller.
// Depends on pisc_pkg for field widths.
interface pisc_in_if import pisc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] setpoint;
  logic signed [DataW-1:0] measurement;

  modport source (output valid, output setpoint, output measurement, input ready);
  modport sink   (input valid, input setpoint, input measurement, output ready);
endinterface

interface pisc_out_if import pisc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] drive;
  logic                    in_deadband;

  modport source (output valid, output drive, output in_deadband, input ready);
  modport sink   (input valid, input drive, input in_deadband, output ready);
endinterface

### rtl/pisc_cfg.sv
// Configuration register bank of the PI speed controller.
// Depends on pisc_pkg for the register codes and reset values.
module pisc_cfg import pisc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  // Write the addressed register, drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadband       <= DeadbandRst;
      cfg_q.drive_min      <= DriveMinRst;
      cfg_q.drive_max      <= DriveMaxRst;
      cfg_q.kp             <= KpRst;
      cfg_q.ki             <= KiRst;
      cfg_q.integral_limit <= IntLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEADBAND:  cfg_q.deadband       <= cfg_data_i[DbW-1:0];
        CFG_DRIVE_MIN: cfg_q.drive_min      <= cfg_data_i;
        CFG_DRIVE_MAX: cfg_q.drive_max      <= cfg_data_i;
        CFG_KP:        cfg_q.kp             <= cfg_data_i;
        CFG_KI:        cfg_q.ki             <= cfg_data_i;
        CFG_INT_LIMIT: cfg_q.integral_limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/pisc_integ.sv
// Integrator stage: deadband test, error and clamped running integral.
// Depends on pisc_pkg for widths, cfg_t and integ_t.
module pisc_integ import pisc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [DataW-1:0] setpoint_i,
  input  logic signed [DataW-1:0] measurement_i,
  input  cfg_t                    cfg_i,
  output integ_t                  stage_o
);

  logic signed [IntW-1:0] integral_q;
  integ_t                 stage_q;

  logic signed [ErrW-1:0] meas_x;
  logic [ErrW-1:0]        mag;
  logic                   in_db;
  logic signed [ErrW-1:0] err;
  logic signed [IntW:0]   sum;
  logic signed [IntW:0]   lim;
  logic signed [IntW-1:0] acc;

  // Deadband test and error
  always_comb begin
    meas_x = {measurement_i[DataW-1], measurement_i};
    mag    = meas_x[ErrW-1] ? ErrW'(-meas_x) : meas_x;
    in_db  = (setpoint_i == '0) && (mag < ErrW'(cfg_i.deadband));
    err    = {setpoint_i[DataW-1], setpoint_i} - meas_x;
  end

  // Accumulate and clamp to the symmetric limit
  always_comb begin
    sum = {integral_q[IntW-1], integral_q} + (IntW+1)'(err);
    lim = (IntW+1)'(cfg_i.integral_limit);
    priority if (sum > lim) begin
      acc = lim[IntW-1:0];
    end else if (sum < -lim) begin
      acc = IntW'(-lim);
    end else begin
      acc = sum[IntW-1:0];
    end
  end

  // Hold integral through deadband items, advance the stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= '0;
      stage_q    <= '0;
    end else if (en_i) begin
      if (valid_i && !in_db) begin
        integral_q <= acc;
      end
      stage_q.valid <= valid_i;
      stage_q.in_db <= in_db;
      stage_q.err   <= err;
      stage_q.acc   <= acc;
    end
  end

  assign stage_o = stage_q;

endmodule

### rtl/pisc_drive.sv
// Drive stages: gain products, then round, clamp and output register.
// Depends on pisc_pkg for widths, cfg_t and integ_t.
module pisc_drive import pisc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  integ_t                  stage_i,
  input  cfg_t                    cfg_i,
  output logic                    valid_o,
  output logic signed [DataW-1:0] drive_o,
  output logic                    in_db_o
);

  logic                     mul_vld_q;
  logic                     mul_db_q;
  logic signed [ProdPW-1:0] prod_p_q;
  logic signed [ProdIW-1:0] prod_i_q;

  logic                     out_vld_q;
  logic                     out_db_q;
  logic signed [DataW-1:0]  drive_q;

  logic signed [ProdPW-1:0] prod_p;
  logic signed [ProdIW-1:0] prod_i;
  logic signed [SumW-1:0]   sum;
  logic signed [SumW-1:0]   rnd;
  logic signed [QW-1:0]     q;
  logic signed [QW-1:0]     lo;
  logic signed [QW-1:0]     hi;
  logic signed [QW-1:0]     lim_lo;
  logic signed [QW-1:0]     lim_hi;
  logic signed [DataW-1:0]  drive_d;

  // Gain products, both gains taken as positive
  always_comb begin
    prod_p = stage_i.err * $signed({1'b0, cfg_i.kp});
    prod_i = stage_i.acc * $signed({1'b0, cfg_i.ki});
  end

  // Sum, round half up, raise to min then lower to max, force zero in deadband
  always_comb begin
    sum    = SumW'(prod_p_q) + SumW'(prod_i_q);
    rnd    = sum + (SumW'(1) <<< (FracSh - 1));
    q      = rnd[SumW-1:FracSh];
    lo     = QW'(cfg_i.drive_min);
    hi     = QW'(cfg_i.drive_max);
    lim_lo = (q < lo) ? lo : q;
    lim_hi = (lim_lo > hi) ? hi : lim_lo;
    drive_d = mul_db_q ? '0 : lim_hi[DataW-1:0];
  end

  // Advance both stages together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      mul_vld_q <= stage_i.valid;
      out_vld_q <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mul_db_q <= stage_i.in_db;
      prod_p_q <= prod_p;
      prod_i_q <= prod_i;
      out_db_q <= mul_db_q;
      drive_q  <= drive_d;
    end
  end

  assign valid_o = out_vld_q;
  assign drive_o = drive_q;
  assign in_db_o = out_db_q;

endmodule

### rtl/pi_speed_controller_deadband.sv
// Top level of the PI speed controller with deadband.
// Depends on pisc_pkg, pisc_if, pisc_cfg, pisc_integ and pisc_drive.
//
// Use: each transfer on in_i carries a setpoint and a measurement (signed
// Q4.12); each produces exactly one transfer on out_o with the clamped drive
// and a flag set when the deadband rule forced zero drive.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while the
// block is idle; registers take effect at the next item.
// Throughput: one item per cycle while out_o is not stalled. Path: each item
// passes the input register, integrator stage, multiply stage and output
// register before it is offered on out_o; the integral add and clamp, with
// integral_q fed back, is the loop that sets the rate.
// Reset: clears the running integral, all valid flags, and loads the default
// gains and limits.
// Stall: while out_o is valid and not taken, the whole pipeline holds and
// in_i.ready is low; when the result is taken, a new item enters that cycle.
module pi_speed_controller_deadband import pisc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  pisc_in_if.sink            in_i,
  pisc_out_if.source         out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_data_i
);

  cfg_t                    cfg;
  integ_t                  integ;
  logic                    en;
  logic                    out_vld;
  logic                    in_vld_q;
  logic signed [DataW-1:0] setpoint_q;
  logic signed [DataW-1:0] measurement_q;

  // Pipeline moves whenever the output register is free or being taken
  assign en         = !out_vld || out_o.ready;
  assign in_i.ready = en;
  assign out_o.valid = out_vld;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      setpoint_q    <= in_i.setpoint;
      measurement_q <= in_i.measurement;
    end
  end

  pisc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pisc_integ u_integ (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (in_vld_q),
    .setpoint_i    (setpoint_q),
    .measurement_i (measurement_q),
    .cfg_i         (cfg),
    .stage_o       (integ)
  );

  pisc_drive u_drive (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .stage_i (integ),
    .cfg_i   (cfg),
    .valid_o (out_vld),
    .drive_o (out_o.drive),
    .in_db_o (out_o.in_deadband)
  );

endmodule

### tb/pi_speed_controller_deadband_tb.sv
// Self-checking testbench for the PI speed controller with deadband.
// Runs a directed table and then randomized phases against an in-house drive predictor.
// Depends on pisc_pkg, the pisc_in_if/pisc_out_if interfaces and pi_speed_controller_deadband.
module pi_speed_controller_deadband_tb import pisc_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit    = 400000;
  localparam int NumPhases     = 7;
  localparam int ItemsPerPhase = 200;
  localparam int HoldPhase     = 4;
  localparam int HoldCycles    = 80;
  localparam int DirRows       = 34;

  // Indexes past the register file, which the block must ignore
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;

  typedef struct packed {
    logic signed [DataW-1:0] drive;
    logic                    in_db;
  } drive_res_t;

  typedef struct packed {
    logic signed [DataW-1:0] sp;
    logic signed [DataW-1:0] meas;
  } sample_t;

  typedef struct packed {
    logic       known;
    drive_res_t want;
  } pinned_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CfgIdxW-1:0]      idx;
    logic [DataW-1:0]        data;
    logic signed [DataW-1:0] sp;
    logic signed [DataW-1:0] meas;
    logic                    known;
    drive_res_t              want;
  } dir_row_t;

  localparam pinned_t NoPin = '0;

  // Directed table: a known result is typed in only where it is obvious
  localparam dir_row_t DirTab [DirRows] = '{
    '{ROW_ITEM, '0, '0, 16'sh0000, 16'sh0000, 1'b1, '{16'sd0, 1'b0}},
    '{ROW_ITEM, '0, '0, 16'sh7FFF, 16'sh8000, 1'b1, '{16'sd4096, 1'b0}},
    '{ROW_ITEM, '0, '0, 16'sh8000, 16'sh7FFF, 1'b1, '{-16'sd4096, 1'b0}},
    '{ROW_CFG, CFG_DEADBAND, 16'd100, '0, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 16'sd0, 16'sd99, 1'b1, '{16'sd0, 1'b1}},
    '{ROW_ITEM, '0, '0, 16'sd0, -16'sd99, 1'b1, '{16'sd0, 1'b1}},
    '{ROW_ITEM, '0, '0, 16'sd0, 16'sd100, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 16'sd0, -16'sd100, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 16'sd1, 16'sd0, 1'b0, '0},
    '{ROW_CFG, CFG_DEADBAND, 16'hFFFF, '0, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 1'b1}},
    '{ROW_ITEM, '0, '0, 16'sd0, 16'sh8000, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 16'sd0, 16'sh7FFF, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 16'sd0, 16'sd32766, 1'b1, '{16'sd0, 1'b1}},
    '{ROW_CFG, CFG_DRIVE_MIN, 16'd1000, '0, '0, 1'b0, '0},
    '{ROW_CFG, CFG_DRIVE_MAX, 16'hFC18, '0, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 16'sd5, 16'sd0, 1'b1, '{-16'sd1000, 1'b0}},
    '{ROW_ITEM, '0, '0, 16'sh8000, 16'sh7FFF, 1'b1, '{-16'sd1000, 1'b0}},
    '{ROW_CFG, CFG_DRIVE_MIN, 16'h8000, '0, '0, 1'b0, '0},
    '{ROW_CFG, CFG_DRIVE_MAX, 16'h7FFF, '0, '0, 1'b0, '0},
    '{ROW_CFG, CFG_KP, 16'hFFFF, '0, '0, 1'b0, '0},
    '{ROW_CFG, CFG_KI, 16'hFFFF, '0, '0, 1'b0, '0},
    '{ROW_CFG, CFG_INT_LIMIT, 16'hFFFF, '0, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 16'sh7FFF, 16'sh8000, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 16'sh7FFF, 16'sh8000, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 16'sh7FFF, 16'sh8000, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 16'sh8000, 16'sh7FFF, 1'b0, '0},
    '{ROW_CFG, CFG_KP, 16'h0000, '0, '0, 1'b0, '0},
    '{ROW_CFG, CFG_KI, 16'h0000, '0, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 16'sd1234, -16'sd77, 1'b1, '{16'sd0, 1'b0}},
    '{ROW_CFG, CFG_INT_LIMIT, 16'h0000, '0, '0, 1'b0, '0},
    '{ROW_CFG, CfgIdxSpareLo, 16'hFFFF, '0, '0, 1'b0, '0},
    '{ROW_CFG, CfgIdxSpareHi, 16'hFFFF, '0, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 16'sh8000, 16'sh8000, 1'b0, '0}
  };

  localparam logic [DataW-1:0] Edges [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
  localparam int SrcIdle [4] = '{0, 62, 0, 6};
  localparam int SnkStall [4] = '{0, 0, 62, 6};

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [DataW-1:0]   cfg_data_i;

  pisc_in_if  in_if ();
  pisc_out_if out_if ();

  pi_speed_controller_deadband DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor copy of the configuration and the running integral
  int db_thr   = DeadbandRst;
  int lo_clamp = DriveMinRst;
  int hi_clamp = DriveMaxRst;
  int kp_gain  = KpRst;
  int ki_gain  = KiRst;
  int int_lim  = IntLimitRst;
  int int_acc  = 0;

  drive_res_t drive_q [$];
  pinned_t    pinned_q [$];

  int fail_cnt      = 0;
  int cycle_cnt     = 0;
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_left     = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Compute the drive for one sample and advance the integral
  function automatic drive_res_t predict_drive(sample_t s);
    int         sp;
    int         meas;
    int         mag;
    int         err;
    longint     acc;
    longint     prod_sum;
    longint     y;
    drive_res_t r;
    sp   = $signed(s.sp);
    meas = $signed(s.meas);
    mag  = (meas < 0) ? -meas : meas;
    if (sp == 0 && mag < db_thr) begin
      r.drive = '0;
      r.in_db = 1'b1;
      return r;
    end
    err = sp - meas;
    acc = longint'(int_acc) + err;
    if (acc < -longint'(int_lim)) acc = -longint'(int_lim);
    if (acc > longint'(int_lim)) acc = int_lim;
    int_acc  = int'(acc);
    prod_sum = longint'(err) * kp_gain + acc * ki_gain;
    // Round half up, then raise to the floor before lowering to the ceiling
    y = (prod_sum + 32768) >>> 16;
    if (y < lo_clamp) y = lo_clamp;
    if (y > hi_clamp) y = hi_clamp;
    r.drive = y[DataW-1:0];
    r.in_db = 1'b0;
    return r;
  endfunction

  task automatic flag_mismatch(string field, longint want, longint got);
    fail_cnt++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Watch both channels and the register port at each rising edge
  always @(posedge clk_i) begin
    sample_t    smp;
    drive_res_t pred;
    drive_res_t want;
    pinned_t    pin;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        smp.sp   = in_if.setpoint;
        smp.meas = in_if.measurement;
        pred     = predict_drive(smp);
        pin      = pinned_q.pop_front();
        drive_q.push_back(pin.known ? pin.want : pred);
      end
      if (out_if.valid && out_if.ready) begin
        if (drive_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: result with none expected, expected none, actual drive %0d db %0b",
                   $time, out_if.drive, out_if.in_deadband);
        end else begin
          want = drive_q.pop_front();
          if (out_if.drive !== want.drive)
            flag_mismatch("drive", want.drive, out_if.drive);
          if (out_if.in_deadband !== want.in_db)
            flag_mismatch("in_deadband", want.in_db, out_if.in_deadband);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEADBAND:  db_thr   = cfg_data_i[DbW-1:0];
          CFG_DRIVE_MIN: lo_clamp = $signed(cfg_data_i);
          CFG_DRIVE_MAX: hi_clamp = $signed(cfg_data_i);
          CFG_KP:        kp_gain  = cfg_data_i;
          CFG_KI:        ki_gain  = cfg_data_i;
          CFG_INT_LIMIT: int_lim  = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Abort a hung run
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one sample and hold it until the transfer; return at the next falling edge
  task automatic offer(sample_t s, pinned_t pin);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid       = 1'b0;
      in_if.setpoint    = 16'($urandom);
      in_if.measurement = 16'($urandom);
      @(negedge clk_i);
    end
    pinned_q.push_back(pin);
    in_if.valid       = 1'b1;
    in_if.setpoint    = s.sp;
    in_if.measurement = s.meas;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (drive_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic load_cfg(logic [DataW-1:0] db, logic [DataW-1:0] mn, logic [DataW-1:0] mx,
                          logic [DataW-1:0] kp, logic [DataW-1:0] ki, logic [DataW-1:0] lim);
    write_reg(CFG_DEADBAND, db);
    write_reg(CFG_DRIVE_MIN, mn);
    write_reg(CFG_DRIVE_MAX, mx);
    write_reg(CFG_KP, kp);
    write_reg(CFG_KI, ki);
    write_reg(CFG_INT_LIMIT, lim);
  endtask

  // Pick the register set for one random phase: defaults, then extremes, then random sets (phase 5 with min above max)
  task automatic set_phase_cfg(int p);
    int lo;
    int hi;
    lo = $urandom_range(32768, 0);
    hi = $urandom_range(32767, 0);
    wait_drained();
    case (p)
      0: load_cfg(DeadbandRst, DriveMinRst, DriveMaxRst, KpRst, KiRst, IntLimitRst);
      1: load_cfg(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      2: load_cfg(16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
      5: load_cfg(16'($urandom_range(2048, 0)), 16'(hi), 16'(-lo), 16'($urandom),
                  16'($urandom), 16'($urandom));
      default: load_cfg(16'($urandom_range(4096, 0)), 16'(-lo), 16'(hi), 16'($urandom),
                        16'($urandom), 16'($urandom));
    endcase
  endtask

  // Mix of deadband probes, full-scale corners and fully random samples
  function automatic sample_t rand_sample();
    sample_t s;
    int      m;
    s.sp   = 16'($urandom);
    s.meas = 16'($urandom);
    case ($urandom_range(9))
      0, 1, 2: begin
        s.sp = '0;
        m    = $urandom_range(db_thr + 1, 0);
        if ($urandom_range(1)) m = -m;
        s.meas = m[DataW-1:0];
      end
      3: begin
        s.sp   = Edges[$urandom_range(3)];
        s.meas = Edges[$urandom_range(3)];
      end
      default: ;
    endcase
    return s;
  endfunction

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    in_if.valid       = 1'b0;
    in_if.setpoint    = '0;
    in_if.measurement = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed table with no idling
    for (int i = 0; i < DirRows; i++) begin
      if (DirTab[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(DirTab[i].idx, DirTab[i].data);
      end else begin
        offer('{DirTab[i].sp, DirTab[i].meas}, '{DirTab[i].known, DirTab[i].want});
      end
    end

    // Random phases, each with its own registers and one of four idling modes
    for (int p = 0; p < NumPhases; p++) begin
      set_phase_cfg(p);
      src_idle_pct  = SrcIdle[p % 4];
      snk_stall_pct = SnkStall[p % 4];
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (n == ItemsPerPhase / 4) wait_drained();
        if (p == HoldPhase && n == ItemsPerPhase / 2) hold_left = HoldCycles;
        offer(rand_sample(), NoPin);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (drive_q.size() != 0) begin
      fail_cnt++;
      $display("%0t: results missing at end, expected 0 pending, actual %0d",
               $time, drive_q.size());
    end
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
